@@ sv/lsoa_pkg.sv @@
package lsoa_pkg;

  // configuration port shape
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_CLEAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_DUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_SPEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_TURN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RAND_SEED   = 3'd6;

  // register widths and reset values
  localparam int LEN_CFG_W = 11;
  localparam int DUR_W     = 8;
  localparam int TURN_W    = 15;
  localparam int CD_W      = 9;

  localparam int          RST_SCAN_LENGTH = 360;
  localparam logic [15:0] RST_STOP_DIST   = 16'd300;
  localparam logic [15:0] RST_FRONT_CLEAR = 16'd1000;
  localparam logic [7:0]  RST_AVOID_DUR   = 8'd10;
  localparam logic [15:0] RST_AVOID_SPEED = 16'd50;
  localparam logic [14:0] RST_AVOID_TURN  = 15'd500;
  localparam logic [15:0] RST_LFSR        = 16'd1;

  // galois lfsr taps
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // divide by three: multiply by 21846 and drop 16 bits, exact up to 4096
  localparam logic [15:0] RECIP3       = 16'd21846;
  localparam int          RECIP3_SHIFT = 16;

  // modulo unit, one dividend bit per cycle
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic acc;          // take one sample into the scan accumulators
    logic start;        // step lfsr and load the modulo unit
    logic div_step;     // one modulo iteration
    logic finish_hold;  // decision without a new countdown
    logic finish_new;   // decision that loads a new countdown
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_last;      // next sample closes the scan
    logic need_start;   // avoidance wanted and no countdown running
  } dp_sts_t;

endpackage

@@ sv/laser_scan_obstacle_avoider_unit.sv @@
// Reactive obstacle avoider fed with laser range samples in scan order, one beat
// per sample. Samples are taken at one per cycle. After the last sample of a scan
// the input stalls for the decision: only the decision state when no new avoidance
// countdown starts; when one starts, an lfsr step, a bit-serial modulo by the
// avoidance duration, then the result write. The last sample of a scan is
// also held off while the previous decision still sits unread in the result
// register; other samples keep flowing. One result beat is produced per scan.
// Configuration writes are always ready and must only be issued while idle.
module laser_scan_obstacle_avoider_unit import lsoa_pkg::*; #(
  parameter int MAX_SCAN   = 1024,
  parameter int RANGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_range_mm,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_avoiding,
  output logic                  out_cruise,
  output logic                  out_stopped,
  output logic                  out_obstruction,
  output logic [15:0]           out_forward_speed_mm_s,
  output logic signed [15:0]    out_turn_rate_mrad_s,
  output logic                  out_turn_updated,
  output logic [15:0]           out_min_left_mm,
  output logic [15:0]           out_min_right_mm,
  output logic [CD_W-1:0]       out_countdown_left,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer
  lsoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // scan accumulators, modulo unit and result register
  lsoa_dp #(
    .MAX_SCAN   (MAX_SCAN),
    .RANGE_BITS (RANGE_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_range_mm            (in_range_mm),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .cmd                    (cmd),
    .sts                    (sts),
    .out_avoiding           (out_avoiding),
    .out_cruise             (out_cruise),
    .out_stopped            (out_stopped),
    .out_obstruction        (out_obstruction),
    .out_forward_speed_mm_s (out_forward_speed_mm_s),
    .out_turn_rate_mrad_s   (out_turn_rate_mrad_s),
    .out_turn_updated       (out_turn_updated),
    .out_min_left_mm        (out_min_left_mm),
    .out_min_right_mm       (out_min_right_mm),
    .out_countdown_left     (out_countdown_left)
  );

  // at most one command a cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc, cmd.start, cmd.div_step, cmd.finish_hold, cmd.finish_new}))
    else $error("controller issued overlapping commands");

  // a decision always shows up as a result beat
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish_hold || cmd.finish_new) |=> out_valid)
    else $error("decision did not raise out_valid");

  // a new turn only comes with avoidance
  a_turn_avoid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_turn_updated) |-> (out_avoiding && !out_cruise))
    else $error("turn updated while cruising");

  // stopped means no forward motion
  a_stop_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stopped) |-> (out_forward_speed_mm_s == 16'd0))
    else $error("forward speed while stopped");

endmodule

@@ sv/lsoa_dp.sv @@
module lsoa_dp import lsoa_pkg::*; #(
  parameter int MAX_SCAN   = 1024,
  parameter int RANGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           in_range_mm,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  output logic                  out_avoiding,
  output logic                  out_cruise,
  output logic                  out_stopped,
  output logic                  out_obstruction,
  output logic [15:0]           out_forward_speed_mm_s,
  output logic signed [15:0]    out_turn_rate_mrad_s,
  output logic                  out_turn_updated,
  output logic [15:0]           out_min_left_mm,
  output logic [15:0]           out_min_right_mm,
  output logic [CD_W-1:0]       out_countdown_left
);

  localparam int NW      = $clog2(MAX_SCAN + 1);
  localparam int IDX_W   = (MAX_SCAN > 1) ? $clog2(MAX_SCAN) : 1;
  localparam int LW      = (NW > LEN_CFG_W) ? NW : LEN_CFG_W;
  localparam int CW      = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam int PW      = NW + 16;
  localparam int RST_LEN = (RST_SCAN_LENGTH > MAX_SCAN) ? MAX_SCAN : RST_SCAN_LENGTH;
  localparam logic [NW-1:0] RST_N_V     = NW'(RST_LEN);
  localparam logic [NW-1:0] RST_THIRD_V = NW'(RST_LEN / 3);
  localparam logic [NW-1:0] RST_HALF_V  = NW'(RST_LEN / 2);
  localparam logic [NW-1:0] RST_UPPER_V = NW'(RST_LEN - RST_LEN / 3);

  // configuration registers
  logic [NW-1:0]     len_r, third_r, half_r, upper_r;
  logic [15:0]       stop_r, front_r, speed_r;
  logic [DUR_W-1:0]  dur_r;
  logic [TURN_W-1:0] turn_r;

  // scan and decision state
  logic [IDX_W-1:0]      idx_r;
  logic [RANGE_BITS-1:0] left_min_r, right_min_r;
  logic                  blocked_r, close_r;
  logic [CD_W-1:0]       cd_r;
  logic [15:0]           held_turn_r;
  logic [15:0]           lfsr_r, lfsr_nxt;
  logic [15:0]           dvd_r;
  logic [DUR_W-1:0]      rem_r;

  // clamped length and its thirds, worked out on the write
  logic [LW-1:0]  len_raw;
  logic [NW-1:0]  len_clamp, len_third;
  logic [PW-1:0]  third_prod;

  always_comb begin
    len_raw = LW'(cfg_data[LEN_CFG_W-1:0]);
    if (len_raw == '0) begin
      len_clamp = NW'(1);
    end else if (len_raw > LW'(MAX_SCAN)) begin
      len_clamp = NW'(MAX_SCAN);
    end else begin
      len_clamp = NW'(len_raw);
    end
    third_prod = PW'(len_clamp) * PW'(RECIP3);
    len_third  = NW'(third_prod >> RECIP3_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= RST_N_V;
      third_r <= RST_THIRD_V;
      half_r  <= RST_HALF_V;
      upper_r <= RST_UPPER_V;
      stop_r  <= RST_STOP_DIST;
      front_r <= RST_FRONT_CLEAR;
      dur_r   <= RST_AVOID_DUR;
      speed_r <= RST_AVOID_SPEED;
      turn_r  <= RST_AVOID_TURN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCAN_LENGTH: begin
          len_r   <= len_clamp;
          third_r <= len_third;
          half_r  <= len_clamp >> 1;
          upper_r <= len_clamp - len_third;
        end
        CFG_STOP_DIST:   stop_r  <= cfg_data;
        CFG_FRONT_CLEAR: front_r <= cfg_data;
        CFG_AVOID_DUR: begin
          dur_r <= (cfg_data[DUR_W-1:0] == '0) ? DUR_W'(1) : cfg_data[DUR_W-1:0];
        end
        CFG_AVOID_SPEED: speed_r <= cfg_data;
        CFG_AVOID_TURN:  turn_r  <= cfg_data[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // sample classification
  logic [CW-1:0]         range_ext, r_cmp;
  logic [RANGE_BITS-1:0] r;
  logic [NW-1:0]         idx_n;
  logic                  in_front, is_close, is_left;

  always_comb begin
    range_ext = CW'(in_range_mm);
    r         = range_ext[RANGE_BITS-1:0];
    r_cmp     = CW'(r);
    idx_n     = NW'(idx_r);
    in_front  = (idx_n > third_r) && (idx_n < upper_r) && (r_cmp < CW'(front_r));
    is_close  = r_cmp < CW'(stop_r);
    is_left   = idx_n > half_r;
  end

  assign sts.is_last = ({1'b0, idx_n} + (NW+1)'(1)) >= {1'b0, len_r};

  // decision terms
  logic avoid_now;
  assign avoid_now      = blocked_r || close_r || (cd_r != '0);
  assign sts.need_start = (blocked_r || close_r) && (cd_r == '0);

  // lfsr step
  always_comb begin
    lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 16'd0);
  end

  // restoring modulo iteration
  logic [DUR_W:0] rem_sh, rem_sub;
  always_comb begin
    rem_sh  = {rem_r, dvd_r[15]};
    rem_sub = rem_sh - {1'b0, dur_r};
  end

  // new countdown and turn
  logic [CD_W-1:0] cd_new, cd_out;
  logic [15:0]     turn_pos, turn_new, turn_out;
  logic            avoid_out;

  always_comb begin
    cd_new    = CD_W'(rem_r) + CD_W'(dur_r) - CD_W'(1);
    turn_pos  = {1'b0, turn_r};
    turn_new  = (left_min_r < right_min_r) ? (16'd0 - turn_pos) : turn_pos;
    avoid_out = cmd.finish_new || avoid_now;
    if (cmd.finish_new) begin
      cd_out = cd_new;
    end else if (avoid_now) begin
      cd_out = cd_r - CD_W'(1);
    end else begin
      cd_out = cd_r;
    end
    turn_out = cmd.finish_new ? turn_new : held_turn_r;
  end

  logic finish;
  assign finish = cmd.finish_hold || cmd.finish_new;

  // scan accumulators and decision state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      left_min_r  <= '1;
      right_min_r <= '1;
      blocked_r   <= 1'b0;
      close_r     <= 1'b0;
      cd_r        <= '0;
      held_turn_r <= '0;
    end else if (finish) begin
      idx_r       <= '0;
      left_min_r  <= '1;
      right_min_r <= '1;
      blocked_r   <= 1'b0;
      close_r     <= 1'b0;
      cd_r        <= cd_out;
      held_turn_r <= turn_out;
    end else if (cmd.acc) begin
      if (in_front) blocked_r <= 1'b1;
      if (is_close) close_r <= 1'b1;
      if (is_left) begin
        if (r < left_min_r) left_min_r <= r;
      end else begin
        if (r < right_min_r) right_min_r <= r;
      end
      if (!sts.is_last) idx_r <= idx_r + IDX_W'(1);
    end
  end

  // lfsr, seeded by a register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= RST_LFSR;
    end else if (cfg_we && (cfg_index == CFG_RAND_SEED)) begin
      lfsr_r <= (cfg_data == '0) ? RST_LFSR : cfg_data;
    end else if (cmd.start) begin
      lfsr_r <= lfsr_nxt;
    end
  end

  // modulo unit registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_r <= lfsr_nxt;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_sh[DUR_W] || (rem_sh >= {1'b0, dur_r}) ?
               rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
    end
  end

  // result register
  logic [CW-1:0] left_ext, right_ext;
  assign left_ext  = CW'(left_min_r);
  assign right_ext = CW'(right_min_r);

  always_ff @(posedge clk) begin
    if (finish) begin
      out_avoiding           <= avoid_out;
      out_cruise             <= !avoid_out;
      out_stopped            <= close_r;
      out_obstruction        <= blocked_r;
      out_forward_speed_mm_s <= (avoid_out && !close_r) ? speed_r : 16'd0;
      out_turn_rate_mrad_s   <= turn_out;
      out_turn_updated       <= cmd.finish_new;
      out_min_left_mm        <= left_ext[15:0];
      out_min_right_mm       <= right_ext[15:0];
      out_countdown_left     <= cd_out;
    end
  end

endmodule

@@ sv/lsoa_ctrl.sv @@
module lsoa_ctrl import lsoa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_SCAN,
    S_DEC,
    S_DIV,
    S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  // input stalls outside the scan state; the last beat of a scan also waits until the result register is free
  assign in_stall  = (state_r != S_SCAN) || (sts.is_last && out_valid_r);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_SCAN: begin
        cmd.acc = in_valid && !in_stall;
        if (cmd.acc && sts.is_last) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.need_start) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cmd.finish_hold = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_new = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_SCAN;
      end
      default: state_nxt = S_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SCAN;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule
